// ----- sv/tacb_pkg.sv -----
// Shared constants, codes and handshake types of the triggered ADC capture buffer.
package tacb_pkg;

  localparam int STORE_DEPTH   = 1024;
  localparam int MAX_CODE_BITS = 16;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 3;

  typedef enum logic [2:0] {
    STAT_STORED  = 3'd0,
    STAT_BELOW   = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_READ_OK = 3'd3,
    STAT_RANGE   = 3'd4
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RANGE_LOW  = 3'd0,
    REG_RANGE_HIGH = 3'd1,
    REG_CODE_WIDTH = 3'd2,
    REG_TRIGGER    = 3'd3,
    REG_GAIN       = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic       go;
    logic [5:0] steps;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

// ----- sv/tacb_div.sv -----
// Restoring divider, one quotient bit per cycle, remainder seeded by the caller.
module tacb_div (
  input  logic               clk,
  input  logic               rst,
  input  tacb_pkg::div_req_t req,
  input  logic [31:0]        rem_init,
  input  logic [31:0]        low_init,
  input  logic [31:0]        divisor,
  output tacb_pkg::div_rsp_t rsp,
  output logic [31:0]        quot
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [32:0] trial;

  // shift the next dividend bit in from the top of the quotient register
  assign trial = {rem, quot[31]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        rem  <= rem_init;
        quot <= low_init;
        cnt  <= req.steps;
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
        end else begin
          rem <= {rem[30:0], quot[31]};
        end
        quot <= {quot[30:0], !trial[32]};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done     = done;
    rsp.rem_zero = (rem == '0);
  end

endmodule

// ----- sv/triggered_adc_capture_buffer.sv -----
// Throughput: one word in flight; the next is taken once the result sits in the output register.
// Both conversion directions share one bit-serial divider (quantize MAX_CODE_BITS steps,
// readback 32 steps).
// Reset: synchronous; clears the entry count, the registers to their defaults and the output valid flag.
// The code store is not cleared; only entries below the count are ever returned.
module triggered_adc_capture_buffer #(
  parameter int STORE_DEPTH   = tacb_pkg::STORE_DEPTH,
  parameter int MAX_CODE_BITS = tacb_pkg::MAX_CODE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tacb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tacb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic signed [31:0]               sample_voltage,
  input  logic [9:0]                       read_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic signed [16:0]               code,
  output logic [10:0]                      stored_count,
  output logic signed [31:0]               scaled_voltage
);

  localparam int MB   = MAX_CODE_BITS;
  localparam int CW   = MB + 1;
  localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNTW = $clog2(STORE_DEPTH + 1);
  localparam int NQ   = 32 + MB;
  localparam int PAW  = 33 + MB;
  localparam int PBW  = 35 + MB;
  localparam int NW   = 36 + MB;
  localparam logic [4:0] MB5 = 5'(MB);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_QMUL, S_QWAIT, S_QSTORE, S_RMUL1, S_RMUL2,
    S_RSUM, S_RABS, S_RCHK, S_RWAIT, S_RGAIN, S_RSCALE, S_EMIT
  } state_t;

  state_t state;

  logic [31:0] range_low;
  logic [31:0] range_high;
  logic [4:0]  code_width;
  logic [31:0] trigger_threshold;
  logic [31:0] gain;

  logic        op_rd;
  logic [31:0] smp;
  logic [9:0]  idx;
  logic [CNTW-1:0] count;

  logic [31:0]            off;
  logic [NQ-1:0]          nprod;
  logic [CW-1:0]          rd_q;
  logic signed [CW-1:0]   cval;
  logic signed [MB+1:0]   dval;
  logic signed [PAW-1:0]  pa;
  logic signed [PBW-1:0]  pb;
  logic signed [NW-1:0]   nsum;
  logic                   neg;
  logic [NW-1:0]          mag;
  logic signed [31:0]     volt;
  logic signed [63:0]     pg;
  logic                   div_go;

  tacb_pkg::status_t    res_status;
  logic signed [CW-1:0] res_code;
  logic signed [31:0]   res_scaled;

  logic [CW-1:0] store [STORE_DEPTH];
  logic          mem_we;
  logic          mem_re;
  logic [31:0]   idx_ext;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // derived conversion terms
  logic [4:0]           bw;
  logic [MB:0]          m_ext;
  logic [MB-1:0]        mval;
  logic [MB-1:0]        half;
  logic                 sgn;
  logic signed [31:0]   lo_s;
  logic signed [31:0]   hi_s;
  logic signed [32:0]   span33;
  logic                 span_pos;
  logic [31:0]          span_rb;
  logic signed [31:0]   vcl;
  logic [32:0]          diff33;
  logic                 trig_hit;

  logic [MB-1:0]          q;
  logic signed [CW-1:0]   tq;
  logic signed [CW-1:0]   code_q;
  logic signed [MB+1:0]   half_ext;
  logic signed [MB+1:0]   dval_next;
  logic signed [PAW-1:0]  pa_next;
  logic signed [PBW-1:0]  pb_next;
  logic [NW-33:0]         mag_hi;
  logic                   volt_sat;
  logic signed [31:0]     volt_div;
  logic signed [63:0]     adj;
  logic signed [47:0]     sh48;
  logic signed [31:0]     scaled_sat;

  tacb_pkg::div_req_t div_req;
  tacb_pkg::div_rsp_t div_rsp;
  logic [31:0]        div_rem_init;
  logic [31:0]        div_low_init;
  logic [31:0]        div_divisor;
  logic [31:0]        div_quot;

  always_comb begin
    if (code_width == 5'd0) begin
      bw = 5'd1;
    end else if (code_width > MB5) begin
      bw = MB5;
    end else begin
      bw = code_width;
    end
  end

  assign m_ext    = ((MB+1)'(1) << bw) - (MB+1)'(1);
  assign mval     = m_ext[MB-1:0];
  assign half     = MB'(1) << (bw - 5'd1);
  assign sgn      = range_low[31];
  assign lo_s     = $signed(range_low);
  assign hi_s     = $signed(range_high);
  assign span33   = $signed({range_high[31], range_high}) - $signed({range_low[31], range_low});
  assign span_pos = !span33[32] && (span33 != '0);
  assign span_rb  = span33[32] ? '0 : span33[31:0];

  // clamp into the range, then take the offset from the bottom
  always_comb begin
    if ($signed(smp) < lo_s) begin
      vcl = lo_s;
    end else if ($signed(smp) > hi_s) begin
      vcl = hi_s;
    end else begin
      vcl = $signed(smp);
    end
  end

  assign diff33   = {vcl[31], vcl} - {lo_s[31], lo_s};
  assign trig_hit = $signed(smp) > $signed(trigger_threshold);

  // signed codes truncate toward zero: a negative code steps back up by one on a remainder
  assign q  = div_quot[MB-1:0];
  assign tq = $signed({1'b0, q}) - $signed({1'b0, half});
  always_comb begin
    if (!sgn) begin
      code_q = $signed({1'b0, q});
    end else if (tq[CW-1] && !div_rsp.rem_zero) begin
      code_q = tq + CW'(1);
    end else begin
      code_q = tq;
    end
  end

  assign half_ext  = sgn ? $signed({2'b00, half}) : '0;
  assign dval_next = $signed({rd_q[CW-1], rd_q}) + half_ext;
  assign pa_next   = lo_s * $signed({1'b0, mval});
  assign pb_next   = dval * $signed({1'b0, span_rb});
  assign mag_hi    = mag[NW-1:32];
  assign volt_sat  = mag_hi >= (NW-32)'(mval);

  always_comb begin
    if (neg) begin
      volt_div = (div_quot > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-div_quot);
    end else begin
      volt_div = div_quot[31] ? 32'sh7fff_ffff : $signed(div_quot);
    end
  end

  // round the product by the Q16.16 gain toward zero, then saturate
  assign adj  = pg + (pg[63] ? 64'sd65535 : 64'sd0);
  assign sh48 = adj[63:16];
  always_comb begin
    if ((&sh48[47:31]) || !(|sh48[47:31])) begin
      scaled_sat = sh48[31:0];
    end else if (sh48[47]) begin
      scaled_sat = 32'sh8000_0000;
    end else begin
      scaled_sat = 32'sh7fff_ffff;
    end
  end

  always_comb begin
    div_req.go    = div_go;
    div_req.steps = op_rd ? 6'd32 : 6'(MB);
    div_rem_init  = op_rd ? 32'(mag_hi) : nprod[NQ-1:MB];
    div_low_init  = op_rd ? mag[31:0] : (32'(nprod[MB-1:0]) << (32 - MB));
    div_divisor   = op_rd ? 32'(mval) : span33[31:0];
  end

  tacb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .rem_init (div_rem_init),
    .low_init (div_low_init),
    .divisor  (div_divisor),
    .rsp      (div_rsp),
    .quot     (div_quot)
  );

  // code store
  assign idx_ext = 32'(idx);
  assign rd_addr = idx_ext[AW-1:0];
  assign wr_addr = count[AW-1:0];
  assign mem_we  = (state == S_QSTORE);
  assign mem_re  = (state == S_DECIDE) && op_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_addr] <= res_code;
    end
    if (mem_re) begin
      rd_q <= store[rd_addr];
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      count             <= '0;
      div_go            <= 1'b0;
      range_low         <= 32'd0;
      range_high        <= 32'd327680;
      code_width        <= 5'd12;
      trigger_threshold <= 32'd0;
      gain              <= 32'd65536;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tacb_pkg::REG_RANGE_LOW:  range_low         <= cfg_data;
          tacb_pkg::REG_RANGE_HIGH: range_high        <= cfg_data;
          tacb_pkg::REG_CODE_WIDTH: code_width        <= cfg_data[4:0];
          tacb_pkg::REG_TRIGGER:    trigger_threshold <= cfg_data;
          tacb_pkg::REG_GAIN:       gain              <= cfg_data;
          default: ;
        endcase
      end

      // drop the taken word unless the emit state loads the next one
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_rd <= (opcode == tacb_pkg::OP_READ);
            smp   <= sample_voltage;
            idx   <= read_index;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_code   <= '0;
          res_scaled <= '0;
          if (!op_rd) begin
            // full test goes before the trigger test
            if (32'(count) >= 32'(STORE_DEPTH)) begin
              res_status <= tacb_pkg::STAT_FULL;
              state      <= S_EMIT;
            end else if (!trig_hit) begin
              res_status <= tacb_pkg::STAT_BELOW;
              state      <= S_EMIT;
            end else if (span_pos) begin
              off   <= diff33[31:0];
              state <= S_QMUL;
            end else begin
              state <= S_QSTORE;
            end
          end else if (idx_ext >= 32'(count) || idx_ext >= 32'(STORE_DEPTH)) begin
            res_status <= tacb_pkg::STAT_RANGE;
            state      <= S_EMIT;
          end else begin
            state <= S_RMUL1;
          end
        end
        S_QMUL: begin
          nprod  <= off * mval;
          div_go <= 1'b1;
          state  <= S_QWAIT;
        end
        S_QWAIT: begin
          div_go <= 1'b0;
          if (div_rsp.done) begin
            res_code <= code_q;
            state    <= S_QSTORE;
          end
        end
        S_QSTORE: begin
          count      <= count + CNTW'(1);
          res_status <= tacb_pkg::STAT_STORED;
          state      <= S_EMIT;
        end
        S_RMUL1: begin
          cval  <= $signed(rd_q);
          dval  <= dval_next;
          pa    <= pa_next;
          state <= S_RMUL2;
        end
        S_RMUL2: begin
          pb    <= pb_next;
          state <= S_RSUM;
        end
        S_RSUM: begin
          nsum  <= NW'(pa) + NW'(pb);
          state <= S_RABS;
        end
        S_RABS: begin
          neg   <= nsum[NW-1];
          mag   <= nsum[NW-1] ? NW'(-nsum) : nsum;
          state <= S_RCHK;
        end
        S_RCHK: begin
          // quotient would not fit 32 bits: saturate without dividing
          if (volt_sat) begin
            volt  <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
            state <= S_RGAIN;
          end else begin
            div_go <= 1'b1;
            state  <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          div_go <= 1'b0;
          if (div_rsp.done) begin
            volt  <= volt_div;
            state <= S_RGAIN;
          end
        end
        S_RGAIN: begin
          pg    <= volt * $signed(gain);
          state <= S_RSCALE;
        end
        S_RSCALE: begin
          res_scaled <= scaled_sat;
          res_code   <= cval;
          res_status <= tacb_pkg::STAT_READ_OK;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            code           <= 17'(res_code);
            stored_count   <= 11'(count);
            scaled_voltage <= res_scaled;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/tacb_chk.sv -----
// Port-level checker for the triggered ADC capture buffer, bound to the top level.
module tacb_chk #(
  parameter int STORE_DEPTH = tacb_pkg::STORE_DEPTH
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         status,
  input logic signed [16:0] code,
  input logic [10:0]        stored_count,
  input logic signed [31:0] scaled_voltage
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(code)
      && $stable(stored_count) && $stable(scaled_voltage))
    else $error("stalled output word changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tacb_pkg::STAT_BELOW || status == tacb_pkg::STAT_FULL
      || status == tacb_pkg::STAT_RANGE) |-> code == '0 && scaled_voltage == '0)
    else $error("rejected word carries a code or voltage");

  a_stored_zero_volt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tacb_pkg::STAT_STORED |-> scaled_voltage == '0
      && stored_count != '0)
    else $error("stored word has a voltage or an empty count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tacb_pkg::STAT_FULL |-> stored_count == 11'(STORE_DEPTH))
    else $error("full reported below the store depth");

endmodule

bind triggered_adc_capture_buffer tacb_chk #(.STORE_DEPTH(STORE_DEPTH)) u_tacb_chk (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the ADC capture buffer: corners, random settings, full store.
module testbench;
  import tacb_pkg::*;

  localparam logic signed [31:0] VOLT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VOLT_MAX = 32'sh7FFF_FFFF;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    status_t            status;
    logic signed [16:0] code;
    logic [10:0]        count;
    logic signed [31:0] scaled;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic signed [31:0] sample_voltage;
  logic [9:0] read_index;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic signed [16:0] code;
  logic [10:0] stored_count;
  logic signed [31:0] scaled_voltage;

  // predicted block state
  logic signed [31:0] lo_reg = 32'sd0;
  logic signed [31:0] hi_reg = 32'sd327680;
  logic [4:0] width_reg = 5'd12;
  logic signed [31:0] trig_reg = 32'sd0;
  logic signed [31:0] gain_reg = 32'sd65536;
  logic signed [16:0] code_mem [STORE_DEPTH];
  int held = 0;

  outcome_t due_outcomes[$];
  int mismatches = 0;
  int words_sent = 0;
  int results_checked = 0;
  int settings_applied = 0;
  int cycle_count = 0;
  int rx_hold = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;

  triggered_adc_capture_buffer u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .sample_voltage (sample_voltage),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .code           (code),
    .stored_count   (stored_count),
    .scaled_voltage (scaled_voltage)
  );

  always #5 clk = ~clk;

  function automatic int code_bits();
    int b;
    b = width_reg;
    if (b < 1) b = 1;
    if (b > MAX_CODE_BITS) b = MAX_CODE_BITS;
    return b;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [16:0] quantize(logic signed [31:0] volt);
    longint lo, hi, span, m, half, v, n, q, r, t;
    int b;
    lo = lo_reg;
    hi = hi_reg;
    span = hi - lo;
    b = code_bits();
    m = (longint'(1) << b) - 1;
    half = longint'(1) << (b - 1);
    if (span <= 0) return '0;
    v = volt;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    n = (v - lo) * m;
    q = n / span;
    r = n % span;
    if (lo >= 0) return 17'(q);
    // signed code: offset by half scale, truncating toward zero
    t = q - half;
    if (t < 0 && r != 0) t += 1;
    return 17'(t);
  endfunction

  function automatic logic signed [31:0] scale_back(logic signed [16:0] c);
    longint lo, hi, span, m, minc, volt;
    int b;
    lo = lo_reg;
    hi = hi_reg;
    span = hi - lo;
    b = code_bits();
    m = (longint'(1) << b) - 1;
    minc = (lo < 0) ? -(longint'(1) << (b - 1)) : 64'sd0;
    if (span < 0) span = 0;
    volt = clip32((lo * m + (longint'(c) - minc) * span) / m);
    return 32'(clip32((volt * longint'(gain_reg)) / 64'sd65536));
  endfunction

  function automatic outcome_t capture_outcome(op_t op, logic signed [31:0] volt,
                                               logic [9:0] idx);
    outcome_t o;
    o.status = STAT_BELOW;
    o.code = '0;
    o.scaled = '0;
    if (op == OP_SAMPLE) begin
      // full test comes before the trigger test
      if (held >= STORE_DEPTH) begin
        o.status = STAT_FULL;
      end else if (volt > trig_reg) begin
        o.code = quantize(volt);
        code_mem[held] = o.code;
        held++;
        o.status = STAT_STORED;
      end
    end else if (idx >= held) begin
      o.status = STAT_RANGE;
    end else begin
      o.code = code_mem[idx];
      o.scaled = scale_back(o.code);
      o.status = STAT_READ_OK;
    end
    o.count = 11'(held);
    return o;
  endfunction

  task automatic offer_word(op_t op, logic signed [31:0] volt, logic [9:0] idx);
    int gap;
    outcome_t due;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    sample_voltage <= volt;
    read_index <= idx;
    do @(posedge clk); while (in_stall);
    due = capture_outcome(op, volt, idx);
    due_outcomes.insert(due_outcomes.size(), due);
    words_sent++;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic await_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_outcomes.size() != 0);
  endtask

  task automatic apply_settings(logic signed [31:0] lo, logic signed [31:0] hi,
                                logic [4:0] bits, logic signed [31:0] trig,
                                logic signed [31:0] gain);
    await_quiet();
    cfg_write <= 1'b1;
    cfg_index <= REG_RANGE_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_RANGE_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= REG_CODE_WIDTH;
    cfg_data <= 32'(bits);
    @(posedge clk);
    cfg_index <= REG_TRIGGER;
    cfg_data <= trig;
    @(posedge clk);
    cfg_index <= REG_GAIN;
    cfg_data <= gain;
    @(posedge clk);
    cfg_write <= 1'b0;
    lo_reg = lo;
    hi_reg = hi;
    width_reg = bits;
    trig_reg = trig;
    gain_reg = gain;
    settings_applied++;
  endtask

  task automatic test_reset_defaults();
    offer_word(OP_READ, 32'sd0, 10'd0);
    offer_word(OP_READ, VOLT_MAX, 10'd1023);
    offer_word(OP_SAMPLE, VOLT_MIN, 10'd0);
    offer_word(OP_SAMPLE, 32'sd0, 10'd1023);
    offer_word(OP_SAMPLE, 32'sd1, 10'd0);
    offer_word(OP_SAMPLE, 32'sd327680, 10'd0);
    offer_word(OP_SAMPLE, 32'sd327681, 10'd0);
    offer_word(OP_SAMPLE, VOLT_MAX, 10'd0);
    offer_word(OP_READ, 32'sd0, 10'd0);
    offer_word(OP_READ, 32'sd0, 10'(held - 1));
    offer_word(OP_READ, 32'sd0, 10'(held));
  endtask

  task automatic test_corner_settings();
    int stale_idx;
    // zero span
    apply_settings(32'sd65536, 32'sd65536, 5'd12, VOLT_MIN, 32'sd65536);
    offer_word(OP_SAMPLE, VOLT_MAX, 10'd0);
    offer_word(OP_READ, 32'sd0, 10'(held - 1));
    // negative span
    apply_settings(32'sd327680, -32'sd327680, 5'd8, VOLT_MIN, 32'sd65536);
    offer_word(OP_SAMPLE, 32'sd0, 10'd0);
    offer_word(OP_READ, 32'sd0, 10'(held - 1));
    // widest span, widest code
    apply_settings(VOLT_MIN, VOLT_MAX, 5'd16, VOLT_MIN, 32'sd65536);
    offer_word(OP_SAMPLE, VOLT_MIN, 10'd0);
    offer_word(OP_SAMPLE, VOLT_MIN + 1, 10'd0);
    offer_word(OP_SAMPLE, 32'sd0, 10'd0);
    offer_word(OP_SAMPLE, VOLT_MAX, 10'd0);
    offer_word(OP_READ, 32'sd0, 10'(held - 1));
    // width 0 behaves as 1
    apply_settings(VOLT_MIN, VOLT_MAX, 5'd0, VOLT_MIN, -32'sd65536);
    offer_word(OP_SAMPLE, VOLT_MAX, 10'd0);
    offer_word(OP_SAMPLE, VOLT_MIN + 1, 10'd0);
    offer_word(OP_READ, 32'sd0, 10'(held - 1));
    // width beyond the maximum clips to it
    apply_settings(-32'sd327680, 32'sd327680, 5'd31, 32'sd0, 32'sd65536);
    offer_word(OP_SAMPLE, 32'sd0, 10'd0);
    offer_word(OP_SAMPLE, 32'sd1, 10'd0);
    offer_word(OP_SAMPLE, 32'sd65536, 10'd0);
    offer_word(OP_READ, 32'sd0, 10'(held - 1));
    // stale code read back under a narrow width: volt and product saturate
    apply_settings(32'sd0, VOLT_MAX, 5'd16, VOLT_MIN, 32'sd65536);
    stale_idx = held;
    offer_word(OP_SAMPLE, VOLT_MAX, 10'd0);
    apply_settings(32'sd0, VOLT_MAX, 5'd1, VOLT_MIN, VOLT_MAX);
    offer_word(OP_READ, 32'sd0, 10'(stale_idx));
    apply_settings(32'sd0, VOLT_MAX, 5'd1, VOLT_MIN, VOLT_MIN);
    offer_word(OP_READ, 32'sd0, 10'(stale_idx));
  endtask

  task automatic test_random_settings();
    longint lo_l, hi_l, trig_l, span;
    logic signed [31:0] gain, v;
    logic [4:0] bits;
    logic [9:0] idx;
    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0: begin
          lo_l = -longint'($urandom_range(1, 1310720));
          hi_l = lo_l + longint'($urandom_range(1, 2621440));
        end
        1: begin
          lo_l = longint'($urandom_range(0, 655360));
          hi_l = lo_l + longint'($urandom_range(1, 2621440));
        end
        2: begin
          lo_l = VOLT_MIN;
          hi_l = VOLT_MAX;
        end
        3: begin
          lo_l = longint'($signed($urandom));
          hi_l = longint'($signed($urandom));
        end
        4: begin
          lo_l = longint'($signed($urandom));
          hi_l = lo_l;
        end
        default: begin
          lo_l = 0;
          hi_l = VOLT_MAX;
        end
      endcase
      case (p)
        0: bits = 5'd1;
        1: bits = 5'd16;
        2: bits = 5'd0;
        3: bits = 5'd31;
        4: bits = 5'd12;
        default: bits = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(1, 16));
      endcase
      case (p % 5)
        0: gain = 32'sd65536;
        1: gain = VOLT_MIN;
        2: gain = VOLT_MAX;
        3: gain = 32'sd0;
        default: gain = $urandom;
      endcase
      trig_l = lo_l - longint'($urandom_range(0, 65536));
      if (trig_l < longint'(VOLT_MIN)) trig_l = VOLT_MIN;
      if (p == 3) trig_l = VOLT_MIN;
      if (p == 7) trig_l = VOLT_MAX;
      if (p == 10) trig_l = longint'($signed($urandom));
      apply_settings(32'(lo_l), 32'(hi_l), bits, 32'(trig_l), gain);
      tx_gaps_on = (p == 0) || ($urandom_range(0, 2) != 0);
      rx_gaps_on = (p == 0) || ($urandom_range(0, 2) != 0);
      if (p == 5) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
      end
      span = longint'(hi_reg) - longint'(lo_reg);
      repeat (55) begin
        if ($urandom_range(0, 9) < 6) begin
          v = $urandom;
          case ($urandom_range(0, 5))
            0, 1, 2: if (span > 0)
              v = 32'(longint'(lo_reg) + (longint'({$urandom, $urandom} >> 1) % (span + 1)));
            3: v = $urandom;
            4: case ($urandom_range(0, 5))
              0: v = lo_reg;
              1: v = hi_reg;
              2: v = trig_reg;
              3: v = trig_reg + 1;
              4: v = VOLT_MIN;
              default: v = VOLT_MAX;
            endcase
            default: v = trig_reg + $signed(32'($urandom_range(1, 4096)));
          endcase
          offer_word(OP_SAMPLE, v, 10'($urandom));
        end else begin
          if (held > 0 && $urandom_range(0, 3) != 0)
            idx = 10'($urandom_range(0, held - 1));
          else
            idx = 10'($urandom_range(0, 1023));
          offer_word(OP_READ, $urandom, idx);
        end
        if ($urandom_range(0, 39) == 0) await_quiet();
      end
    end
  endtask

  task automatic test_full_store();
    logic signed [31:0] v;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    apply_settings(VOLT_MIN, VOLT_MAX, 5'd12, VOLT_MIN, 32'sd65536);
    while (held < STORE_DEPTH) begin
      v = $urandom;
      if (v == VOLT_MIN) v = 32'sd0;
      if ($urandom_range(0, 9) == 0)
        offer_word(OP_READ, v, 10'($urandom_range(0, held - 1)));
      else
        offer_word(OP_SAMPLE, v, 10'($urandom));
    end
    // full store wins over the trigger test
    offer_word(OP_SAMPLE, VOLT_MIN, 10'd0);
    offer_word(OP_SAMPLE, VOLT_MAX, 10'd0);
    offer_word(OP_SAMPLE, $urandom, 10'd0);
    offer_word(OP_READ, 32'sd0, 10'd1023);
    offer_word(OP_READ, 32'sd0, 10'd0);
    apply_settings(-32'sd655360, 32'sd655360, 5'd4, VOLT_MAX, 32'sd131072);
    offer_word(OP_SAMPLE, VOLT_MAX, 10'd0);
    repeat (6) offer_word(OP_READ, 32'sd0, 10'($urandom));
    await_quiet();
  endtask

  // receiver: after each taken result, stall for a drawn number of cycles
  always @(posedge clk) begin : receiver
    int pause;
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_stall <= (rx_hold != 1);
    end else if (out_valid && !out_stall) begin
      pause = rx_gaps_on ? $urandom_range(0, 6) : 0;
      rx_hold <= pause;
      out_stall <= (pause != 0);
    end
  end

  always @(posedge clk) begin : outcome_check
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_outcomes.size() == 0) begin
        $error("unexpected result word: status %0d code %0d", status, code);
        mismatches++;
      end else begin
        want = due_outcomes.pop_front();
        results_checked++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (code !== want.code) begin
          $error("code: expected %0d, got %0d", want.code, code);
          mismatches++;
        end
        if (stored_count !== want.count) begin
          $error("stored_count: expected %0d, got %0d", want.count, stored_count);
          mismatches++;
        end
        if (scaled_voltage !== want.scaled) begin
          $error("scaled_voltage: expected %0d, got %0d", want.scaled, scaled_voltage);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_RANGE_LOW;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= OP_SAMPLE;
    sample_voltage <= '0;
    read_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_corner_settings();
    test_random_settings();
    test_full_store();

    await_quiet();
    repeat (60) @(posedge clk);
    $display("Sent %0d words under %0d register settings, checked %0d results.",
             words_sent, settings_applied, results_checked);
    $display("Store filled to %0d entries; %0d mismatches seen.", held, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
